>>> hdl/mcfp_pkg.sv
// Shared constants, types and character helpers for the motor command frame parser.
package mcfp_pkg;

  localparam int FRAME_LEN  = 20;
  localparam int NUM_MOTORS = 4;
  localparam int CNT_W      = $clog2(FRAME_LEN + 1);
  localparam int IDX_W      = $clog2(NUM_MOTORS);
  localparam int PWR_W      = 10;
  localparam int OUT_PWR_W  = 11;

  localparam logic [7:0] CHAR_NL   = 8'd10;
  localparam logic [7:0] DIR_FWD   = 8'd70;
  localparam logic [7:0] DIR_REV   = 8'd82;
  localparam logic [7:0] DIR_BRAKE = 8'd66;

  localparam logic [8*FRAME_LEN-1:0] ALL_STOP_FRAME = "1R0002R0003R0004R000";

  typedef struct packed {
    logic                                all_stop;
    logic [NUM_MOTORS-1:0][7:0]          dir;
    logic [NUM_MOTORS-1:0][PWR_W-1:0]    pwr;
  } cmd_desc_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic [PWR_W-1:0] parse_power(input logic [7:0] c0,
                                                   input logic [7:0] c1,
                                                   input logic [7:0] c2);
    logic [PWR_W-1:0] v;
    v = '0;
    if (is_digit(c0)) begin
      v = {6'd0, c0[3:0]};
      if (is_digit(c1)) begin
        v = PWR_W'(v * PWR_W'(10)) + {6'd0, c1[3:0]};
        if (is_digit(c2)) begin
          v = PWR_W'(v * PWR_W'(10)) + {6'd0, c2[3:0]};
        end
      end
    end
    return v;
  endfunction

endpackage

>>> hdl/mcfp_front.sv
// Front end: collects and trims frame bytes, validates length and decodes each frame.
module mcfp_front
  import mcfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic      q_full,
  output logic      q_push,
  output cmd_desc_t q_desc
);

  logic [7:0]       store_r [FRAME_LEN];
  logic [CNT_W-1:0] char_cnt_r, char_cnt_nxt;
  logic [CNT_W-1:0] content_len_r, content_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             take;
  logic             is_nl;
  logic             ws;
  logic             store_wr;
  logic             frame_ok;
  logic             stop_match;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign is_nl    = (in_rx_byte == CHAR_NL);
  assign ws       = is_ws(in_rx_byte);
  assign store_wr = take && !is_nl && !(ws && char_cnt_r == '0) &&
                    (char_cnt_r < CNT_W'(FRAME_LEN));
  assign frame_ok = !ovf_r && (content_len_r == CNT_W'(FRAME_LEN));
  assign q_push   = take && is_nl && frame_ok;

  always_comb begin
    stop_match = 1'b1;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (store_r[i] != ALL_STOP_FRAME[8*(FRAME_LEN-1-i) +: 8]) begin
        stop_match = 1'b0;
      end
    end
  end

  always_comb begin
    q_desc.all_stop = stop_match;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      q_desc.dir[m] = store_r[5*m+1];
      q_desc.pwr[m] = parse_power(store_r[5*m+2], store_r[5*m+3], store_r[5*m+4]);
    end
  end

  always_comb begin
    char_cnt_nxt    = char_cnt_r;
    content_len_nxt = content_len_r;
    ovf_nxt         = ovf_r;
    if (take) begin
      if (is_nl) begin
        char_cnt_nxt    = '0;
        content_len_nxt = '0;
        ovf_nxt         = 1'b0;
      end else if (store_wr) begin
        char_cnt_nxt = char_cnt_r + CNT_W'(1);
        if (!ws) begin
          content_len_nxt = char_cnt_r + CNT_W'(1);
        end
      end else if (!ws) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_cnt_r    <= '0;
      content_len_r <= '0;
      ovf_r         <= 1'b0;
    end else begin
      char_cnt_r    <= char_cnt_nxt;
      content_len_r <= content_len_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[char_cnt_r] <= in_rx_byte;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    char_cnt_r <= CNT_W'(FRAME_LEN))
    else $error("character count past frame length");

  assert property (@(posedge clk) disable iff (!rst_n)
    content_len_r <= char_cnt_r)
    else $error("content length ahead of character count");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (char_cnt_r == '0) && !ovf_r)
    else $error("frame state not cleared after push");

endmodule

>>> hdl/mcfp_queue.sv
// Small register queue of decoded frames between front and back.
module mcfp_queue
  import mcfp_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_desc_t push_desc,
  input  logic      pop,
  output cmd_desc_t pop_desc,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_desc_t     mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after push");

endmodule

>>> hdl/mcfp_back.sv
// Back end: issues four motor commands per frame and tracks stored directions.
module mcfp_back
  import mcfp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  cmd_desc_t                   q_desc,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [IDX_W-1:0]            out_motor_index,
  output logic                        out_drive,
  output logic signed [OUT_PWR_W-1:0] out_power,
  output logic                        out_guard_stop,
  output logic                        out_last
);

  cmd_desc_t                   cur_r;
  logic                        busy_r;
  logic [IDX_W-1:0]            idx_r;
  logic [7:0]                  prev_dir_r [NUM_MOTORS];
  logic                        out_valid_r;
  logic [IDX_W-1:0]            motor_r;
  logic                        drive_r, drive_nxt;
  logic signed [OUT_PWR_W-1:0] power_r, power_nxt;
  logic                        guard_r, guard_nxt;
  logic                        last_r;
  logic                        load;
  logic [7:0]                  dir;
  logic [OUT_PWR_W-1:0]        pos;

  assign q_pop = !busy_r && !q_empty;
  assign load  = busy_r && (!out_valid_r || out_ready);
  assign dir   = cur_r.dir[idx_r];
  assign pos   = {1'b0, cur_r.pwr[idx_r]};

  always_comb begin
    drive_nxt = 1'b0;
    power_nxt = '0;
    guard_nxt = 1'b0;
    if (!cur_r.all_stop) begin
      guard_nxt = (dir != prev_dir_r[idx_r]);
      if (dir == DIR_FWD) begin
        drive_nxt = 1'b1;
        power_nxt = pos;
      end else if (dir == DIR_REV) begin
        drive_nxt = 1'b1;
        power_nxt = OUT_PWR_W'(~pos + OUT_PWR_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        prev_dir_r[m] <= DIR_BRAKE;
      end
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load) begin
        idx_r <= idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(NUM_MOTORS - 1)) begin
          busy_r <= 1'b0;
        end
        prev_dir_r[idx_r] <= cur_r.all_stop ? DIR_BRAKE : dir;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (load) begin
      motor_r <= idx_r;
      drive_r <= drive_nxt;
      power_r <= power_nxt;
      guard_r <= guard_nxt;
      last_r  <= (idx_r == IDX_W'(NUM_MOTORS - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_index = motor_r;
  assign out_drive       = drive_r;
  assign out_power       = power_r;
  assign out_guard_stop  = guard_r;
  assign out_last        = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r == IDX_W'(NUM_MOTORS - 1)) |=> !busy_r)
    else $error("back end still busy after last command");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !drive_r) |-> (power_r == '0))
    else $error("nonzero power on stop command");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (motor_r == IDX_W'(NUM_MOTORS - 1)))
    else $error("last flag on wrong motor");

endmodule

>>> hdl/motor_command_frame_parser_top.sv
// With the back end idle, a frame's four commands pass through the queue, the back end's
// frame register and its output register once its newline is accepted, then leave one per
// cycle while out_ready is high. Input: one byte per cycle while the queue is not full. The
// back end takes a frame only when idle, so a stalled output fills the queue and stalls input.
// Reset (rst_n low, synchronous): clears counters, queue and output valid and sets
// every stored direction to brake; the frame byte store is not cleared.
module motor_command_frame_parser_top
  import mcfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [IDX_W-1:0]            out_motor_index,
  output logic                        out_drive,
  output logic signed [OUT_PWR_W-1:0] out_power,
  output logic                        out_guard_stop,
  output logic                        out_last
);

  cmd_desc_t push_desc;
  cmd_desc_t pop_desc;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  mcfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (full),
    .q_push    (push),
    .q_desc    (push_desc)
  );

  mcfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .pop_desc (pop_desc),
    .full     (full),
    .empty    (empty)
  );

  mcfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (empty),
    .q_desc         (pop_desc),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_motor_index(out_motor_index),
    .out_drive      (out_drive),
    .out_power      (out_power),
    .out_guard_stop (out_guard_stop),
    .out_last       (out_last)
  );

endmodule

>>> verif/motor_command_frame_parser_top_test.sv
// Self-checking testbench for the motor command frame parser: byte stream in, motor commands out.
module motor_command_frame_parser_top_test;
  import mcfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_MARK  = 256;
  localparam int HOLD_CYCLES = 800;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_BYTES = 170;

  typedef struct packed {
    logic [IDX_W-1:0]     motor;
    logic                 drive;
    logic [OUT_PWR_W-1:0] power;
    logic                 guard;
    logic                 last_cmd;
  } motor_cmd_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_rx_byte = 8'd0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [IDX_W-1:0]            out_motor_index;
  logic                        out_drive;
  logic signed [OUT_PWR_W-1:0] out_power;
  logic                        out_guard_stop;
  logic                        out_last;

  motor_command_frame_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_index (out_motor_index),
    .out_drive       (out_drive),
    .out_power       (out_power),
    .out_guard_stop  (out_guard_stop),
    .out_last        (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int         pending[$];
  motor_cmd_t expected_cmds[$];

  logic [7:0]  frame_chars[FRAME_LEN];
  int unsigned kept_len = 0;
  int unsigned body_len = 0;
  bit          too_long = 1'b0;
  logic [7:0]  motor_dir[NUM_MOTORS];

  int   bytes_sent = 0;
  int   frames_taken = 0;
  int   frames_dropped = 0;
  int   cmds_checked = 0;
  int   errors = 0;
  int   tx_wait = 0;
  int   tx_calm = 0;
  int   rx_wait = 0;
  int   rx_calm = 0;
  int   hold_at = 32'h7fff_ffff;
  int   quiet_cycles = 0;
  logic rx_hold = 1'b0;

  function automatic bit blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int unsigned lead_digits(input int pos);
    int unsigned v;
    logic [7:0]  c;
    v = 0;
    for (int k = 0; k < 3; k++) begin
      c = frame_chars[pos + k];
      if (c < "0" || c > "9") break;
      v = v * 10 + (c - "0");
    end
    return v;
  endfunction

  // Mostly no gap, some short, a few long; calm runs give stretches with no idling.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic take_byte(input logic [7:0] c);
    motor_cmd_t  cmd;
    logic [7:0]  dir;
    int unsigned mag;
    bit          good;
    bit          halt_all;
    if (c != CHAR_NL) begin
      if (blank(c) && kept_len == 0) return;
      if (kept_len < FRAME_LEN) begin
        frame_chars[kept_len] = c;
        kept_len++;
        if (!blank(c)) body_len = kept_len;
      end else if (!blank(c)) begin
        too_long = 1'b1;
      end
      return;
    end
    good = !too_long && body_len == FRAME_LEN;
    kept_len = 0;
    body_len = 0;
    too_long = 1'b0;
    if (!good) begin
      frames_dropped++;
      return;
    end
    frames_taken++;
    halt_all = 1'b1;
    for (int k = 0; k < FRAME_LEN; k++)
      if (frame_chars[k] != ALL_STOP_FRAME[8*(FRAME_LEN-1-k) +: 8]) halt_all = 1'b0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      dir = frame_chars[5*m + 1];
      mag = lead_digits(5*m + 2);
      cmd.motor = IDX_W'(m);
      cmd.last_cmd = (m == NUM_MOTORS - 1);
      if (halt_all) begin
        cmd.drive = 1'b0;
        cmd.power = '0;
        cmd.guard = 1'b0;
        motor_dir[m] = DIR_BRAKE;
      end else begin
        cmd.drive = (dir == DIR_FWD) || (dir == DIR_REV);
        if (dir == DIR_FWD) cmd.power = OUT_PWR_W'(mag);
        else if (dir == DIR_REV) cmd.power = OUT_PWR_W'(-int'(mag));
        else cmd.power = '0;
        cmd.guard = (dir != motor_dir[m]);
        motor_dir[m] = dir;
      end
      expected_cmds.push_back(cmd);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_command();
    motor_cmd_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected command for motor %0d", out_motor_index));
      return;
    end
    want = expected_cmds.pop_front();
    cmds_checked++;
    if (out_motor_index !== want.motor)
      report_mismatch($sformatf("motor_index got %0d want %0d", out_motor_index, want.motor));
    if (out_drive !== want.drive)
      report_mismatch($sformatf("motor %0d drive got %0b want %0b",
                                want.motor, out_drive, want.drive));
    if (out_power !== want.power)
      report_mismatch($sformatf("motor %0d power got %0d want %0d",
                                want.motor, out_power, $signed(want.power)));
    if (out_guard_stop !== want.guard)
      report_mismatch($sformatf("motor %0d guard_stop got %0b want %0b",
                                want.motor, out_guard_stop, want.guard));
    if (out_last !== want.last_cmd)
      report_mismatch($sformatf("motor %0d last got %0b want %0b",
                                want.motor, out_last, want.last_cmd));
  endtask

  // Driver: advance to the next request only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 && pending[0] == DRAIN_MARK) begin
          in_valid <= 1'b0;
          if (expected_cmds.size() == 0) void'(pending.pop_front());
        end else if (pending.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= 8'(pending.pop_front());
          tx_wait = idle_len(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each command taken, then pick the next ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_command();
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_wait = idle_len(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("motor_command_frame_parser_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the receiver off so the parser fills up and stalls its input.
  initial begin
    while (bytes_sent < hold_at) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending.push_back(s[i]);
  endtask

  task automatic queue_all_stop();
    for (int k = 0; k < FRAME_LEN; k++)
      pending.push_back(ALL_STOP_FRAME[8*(FRAME_LEN-1-k) +: 8]);
  endtask

  function automatic logic [7:0] any_but_nl();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_NL);
    return b;
  endfunction

  function automatic logic [7:0] solid_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (blank(b));
    return b;
  endfunction

  function automatic logic [7:0] pad_char();
    case ($urandom_range(0, 4))
      0: return 8'd9;
      1: return 8'd11;
      2: return 8'd12;
      3: return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  task automatic queue_random_frame();
    int         kind;
    int         n;
    int         r;
    logic [7:0] body[FRAME_LEN];
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(0, 2)) pending.push_back(pad_char());
      queue_all_stop();
      repeat ($urandom_range(0, 2)) pending.push_back(pad_char());
      pending.push_back(CHAR_NL);
    end else if (kind < 74) begin
      for (int k = 0; k < FRAME_LEN; k++) begin
        r = $urandom_range(0, 99);
        case (k % 5)
          0: body[k] = (r < 80) ? 8'("1" + k / 5) : solid_char();
          1: body[k] = (r < 40) ? DIR_FWD : (r < 78) ? DIR_REV :
                       (r < 86) ? DIR_BRAKE : any_but_nl();
          default: body[k] = (r < 90) ? 8'($urandom_range("0", "9")) : any_but_nl();
        endcase
      end
      if (blank(body[0])) body[0] = "0";
      if (blank(body[FRAME_LEN-1])) body[FRAME_LEN-1] = "9";
      repeat ($urandom_range(0, 2)) pending.push_back(pad_char());
      foreach (body[k]) pending.push_back(body[k]);
      repeat ($urandom_range(0, 3)) pending.push_back(pad_char());
      pending.push_back(CHAR_NL);
    end else if (kind < 90) begin
      n = $urandom_range(0, 28);
      repeat (n) pending.push_back(any_but_nl());
      pending.push_back(CHAR_NL);
    end else begin
      repeat ($urandom_range(1, 8)) pending.push_back($urandom_range(0, 255));
    end
  endtask

  initial begin
    int base;
    int drain_done;
    foreach (motor_dir[m]) motor_dir[m] = DIR_BRAKE;

    queue_text("1F0002R9993X0504F123\n");
    queue_text(" \t\r1F9992R0013X0504R123 \v\f\n");
    queue_all_stop();
    pending.push_back(CHAR_NL);
    queue_text("1F5-92R 123B1x04F12A\n");
    pending.push_back(8'h00);
    queue_text("F999");
    pending.push_back(8'hFF);
    queue_text("R0013");
    pending.push_back(8'hD2);
    queue_text("0504F12");
    pending.push_back(8'h00);
    pending.push_back(CHAR_NL);
    queue_text("1F0992F0993F0994F099    \t\t  \n");
    queue_text("1F0002R0003R0004R0005\n");
    queue_text("1F0002R0003R0004R000   X\n");
    queue_text("1F0002R0003R0004R00\n");
    queue_text("1F0002R0003R0004R00 \n");
    queue_text("\n");
    queue_text("  \t\n");
    queue_text("1R0002R0003R0004R001\n");
    pending.push_back(DRAIN_MARK);

    base = pending.size();
    hold_at = base + 60;
    drain_done = 0;
    while (pending.size() - base < RANDOM_BYTES) begin
      queue_random_frame();
      if (!drain_done && pending.size() - base > RANDOM_BYTES / 2) begin
        pending.push_back(CHAR_NL);
        pending.push_back(DRAIN_MARK);
        drain_done = 1;
      end
    end
    pending.push_back(CHAR_NL);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid || expected_cmds.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (expected_cmds.size() != 0)
      report_mismatch($sformatf("%0d commands never arrived", expected_cmds.size()));

    $display("Sent %0d bytes: %0d frames accepted, %0d rejected, %0d commands checked.",
             bytes_sent, frames_taken, frames_dropped, cmds_checked);
    $display("Covered trimming, overlong and short frames, all-stop, odd directions, stalls.");
    if (errors == 0) begin
      $display("motor_command_frame_parser_top_test: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("motor_command_frame_parser_top_test: FAIL");
    end
    $finish;
  end

endmodule
